### design/motor_speed_pid_controller_unit_assert.svh
// Assertion macros for the motor speed PID controller unit.
`ifndef MOTOR_SPEED_PID_CONTROLLER_UNIT_ASSERT_SVH
`define MOTOR_SPEED_PID_CONTROLLER_UNIT_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define MSPC_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mspc: same-cycle check failed");

// Check that a condition implies another in the following cycle.
`define MSPC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mspc: next-cycle check failed");

`endif

### design/mspc_pkg.sv
// Shared types and constants of the motor speed PID controller unit.
`default_nettype none

package mspc_pkg;

   // Field widths fixed by the register map and the result word
   localparam int SETPOINT_W = 20;
   localparam int GAIN_W     = 16;
   localparam int SCALE_W    = 16;
   localparam int WINDOW_W   = 16;
   localparam int SPEED_W    = 20;
   localparam int ERR_W      = 21;
   localparam int DERIV_W    = 22;
   localparam int DUTY_W     = 8;
   localparam int FRAC_OUT   = 20;
   localparam int SPEED_SH   = 8;
   localparam int TERM_LOG2  = 60;
   localparam int STEP_W     = $clog2(GAIN_W);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SETPOINT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INTERVAL = 3'd5;

   // Register reset values
   localparam logic [SETPOINT_W-1:0] SETPOINT_RST = 20'd17920;
   localparam logic [GAIN_W-1:0]     GAIN_P_RST   = 16'd4096;
   localparam logic [GAIN_W-1:0]     GAIN_I_RST   = 16'd410;
   localparam logic [GAIN_W-1:0]     GAIN_D_RST   = 16'd41;
   localparam logic [SCALE_W-1:0]    SCALE_RST    = 16'd9600;
   localparam logic [WINDOW_W-1:0]   INTERVAL_RST = 16'd40;

   localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};
   localparam logic [DUTY_W-1:0]  DUTY_MAX  = {DUTY_W{1'b1}};

   // Sequencer states
   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_SPEED    = 7'b0000010,
      ST_SATURATE = 7'b0000100,
      ST_ERROR    = 7'b0001000,
      ST_MUL      = 7'b0010000,
      ST_ADD      = 7'b0100000,
      ST_FINISH   = 7'b1000000
   } state_type;

   // Which PID term the shared multiplier is working on
   typedef enum logic [1:0] {
      PH_P = 2'd0,
      PH_I = 2'd1,
      PH_D = 2'd2
   } phase_type;

endpackage

`default_nettype wire

### design/motor_speed_pid_controller_unit.sv
// Motor speed PID controller: encoder edge counting, speed window and bit-serial PID.
//
// Usage:
//  - req channel: one word per control tick carrying the sampled encoder A level.
//  - rsp channel: one word per tick with duty, last measured speed and a flag
//    that is set when the measurement window closed on that tick.
//  - csr channel: register writes (index, data), always ready; write only
//    while the block is idle.
// Sequence: a taken word goes through the speed product and its saturation
// when the window closes, then the error step, then the P, I and D products,
// each added into the output sum in an add step, then the finish step. A
// new word is taken in the cycle rsp_valid rises. The shared shift-and-add
// multiplier walks the 16 gain or scale bits one per cycle for the speed
// product when a window closes and for each of the three PID terms.
// Stall: the result sits in an output register until rsp_ready; the block
// accepts the next tick meanwhile and holds the following result until the
// output register is free.
// Reset: registers return to their documented defaults and the edge and window
// counters, the error sum and the last error clear; no clearing pass is needed.
`default_nettype none
`include "motor_speed_pid_controller_unit_assert.svh"

module motor_speed_pid_controller_unit #(
   parameter int COUNT_WIDTH = 16,
   parameter int SUM_WIDTH   = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [mspc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [mspc_pkg::CSR_DATA_W-1:0]      csr_data,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_encoder_a,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [mspc_pkg::DUTY_W-1:0]               rsp_duty,
   output logic [mspc_pkg::SPEED_W-1:0]              rsp_speed_rpm,
   output logic                                      rsp_speed_updated
);

   // Multiplicand, product and output-sum widths
   localparam int MW0 = (SUM_WIDTH > mspc_pkg::DERIV_W) ? SUM_WIDTH : mspc_pkg::DERIV_W;
   localparam int MW  = (MW0 > COUNT_WIDTH + 1) ? MW0 : COUNT_WIDTH + 1;
   localparam int PW  = MW + mspc_pkg::GAIN_W;
   localparam int TW  = ((PW > mspc_pkg::TERM_LOG2 + 1) ? PW : mspc_pkg::TERM_LOG2 + 1) + 2;

   localparam logic signed [TW-1:0] TERM_POS =
      {{(TW - mspc_pkg::TERM_LOG2 - 1){1'b0}}, 1'b1, {mspc_pkg::TERM_LOG2{1'b0}}};
   localparam logic signed [TW-1:0] TERM_NEG = -TERM_POS;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

   // Configuration registers
   logic [mspc_pkg::SETPOINT_W-1:0] setpoint_ff;
   logic [mspc_pkg::GAIN_W-1:0]     gain_p_ff;
   logic [mspc_pkg::GAIN_W-1:0]     gain_i_ff;
   logic [mspc_pkg::GAIN_W-1:0]     gain_d_ff;
   logic [mspc_pkg::SCALE_W-1:0]    scale_ff;
   logic [mspc_pkg::WINDOW_W-1:0]   interval_ff;

   // Control and measurement state
   mspc_pkg::state_type state_ff, state_in;
   mspc_pkg::phase_type phase_ff, phase_in;
   logic                            last_level_ff, last_level_in;
   logic [COUNT_WIDTH-1:0]          edge_count_ff, edge_count_in;
   logic [mspc_pkg::WINDOW_W-1:0]   window_ff, window_in;
   logic [mspc_pkg::SPEED_W-1:0]    speed_ff, speed_in;
   logic signed [SUM_WIDTH-1:0]     error_sum_ff, error_sum_in;
   logic signed [mspc_pkg::ERR_W-1:0]   last_error_ff, last_error_in;
   logic signed [mspc_pkg::DERIV_W-1:0] deriv_ff, deriv_in;
   logic                            updated_ff, updated_in;

   // Shared bit-serial multiplier and output sum
   logic signed [PW-1:0]            mcand_ff, mcand_in;
   logic [mspc_pkg::GAIN_W-1:0]     mplier_ff, mplier_in;
   logic signed [PW-1:0]            prod_ff, prod_in;
   logic [mspc_pkg::STEP_W-1:0]     step_ff, step_in;
   logic signed [TW-1:0]            total_ff, total_in;

   // Output register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [mspc_pkg::DUTY_W-1:0]     rsp_duty_ff, rsp_duty_in;
   logic [mspc_pkg::SPEED_W-1:0]    rsp_speed_ff, rsp_speed_in;
   logic                            rsp_updated_ff, rsp_updated_in;

   // Combinational helpers
   logic                            req_take;
   logic                            rsp_load;
   logic [COUNT_WIDTH-1:0]          edge_next;
   logic [mspc_pkg::WINDOW_W-1:0]   window_next;
   logic [mspc_pkg::WINDOW_W-1:0]   limit;
   logic                            window_close;
   logic signed [mspc_pkg::ERR_W-1:0]   err_val;
   logic signed [SUM_WIDTH:0]       sum_ext;
   logic signed [TW-1:0]            prod_ext;
   logic signed [TW-1:0]            term_clamped;
   logic [mspc_pkg::DUTY_W-1:0]     duty_val;
   logic                            mul_last;

   assign csr_ready         = 1'b1;
   assign req_ready         = (state_ff == mspc_pkg::ST_IDLE);
   assign req_take          = req_valid && req_ready;
   assign rsp_load          = (state_ff == mspc_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_duty          = rsp_duty_ff;
   assign rsp_speed_rpm     = rsp_speed_ff;
   assign rsp_speed_updated = rsp_updated_ff;

   // Write configuration registers; drop unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= mspc_pkg::SETPOINT_RST;
         gain_p_ff   <= mspc_pkg::GAIN_P_RST;
         gain_i_ff   <= mspc_pkg::GAIN_I_RST;
         gain_d_ff   <= mspc_pkg::GAIN_D_RST;
         scale_ff    <= mspc_pkg::SCALE_RST;
         interval_ff <= mspc_pkg::INTERVAL_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mspc_pkg::REG_SETPOINT: setpoint_ff <= csr_data;
            mspc_pkg::REG_GAIN_P:   gain_p_ff   <= csr_data[mspc_pkg::GAIN_W-1:0];
            mspc_pkg::REG_GAIN_I:   gain_i_ff   <= csr_data[mspc_pkg::GAIN_W-1:0];
            mspc_pkg::REG_GAIN_D:   gain_d_ff   <= csr_data[mspc_pkg::GAIN_W-1:0];
            mspc_pkg::REG_SCALE:    scale_ff    <= csr_data[mspc_pkg::SCALE_W-1:0];
            mspc_pkg::REG_INTERVAL: interval_ff <= csr_data[mspc_pkg::WINDOW_W-1:0];
            default: ;
         endcase
      end
   end

   // Edge count and window tick for the word on the input
   always_comb begin
      edge_next = edge_count_ff;
      if (req_encoder_a && !last_level_ff && (edge_count_ff != COUNT_MAX)) begin
         edge_next = edge_count_ff + 1'b1;
      end
      window_next  = window_ff + 1'b1;
      limit        = (interval_ff == '0) ? mspc_pkg::WINDOW_W'(1) : interval_ff;
      window_close = (window_next == '0) || (window_next >= limit);
   end

   // Error, saturating error sum and clamped term
   always_comb begin
      err_val  = $signed({1'b0, setpoint_ff}) - $signed({1'b0, speed_ff});
      sum_ext  = $signed({error_sum_ff[SUM_WIDTH-1], error_sum_ff})
               + $signed({{(SUM_WIDTH + 1 - mspc_pkg::ERR_W){err_val[mspc_pkg::ERR_W-1]}},
                          err_val});
      prod_ext = $signed({{(TW-PW){prod_ff[PW-1]}}, prod_ff});
      if (prod_ext > TERM_POS) begin
         term_clamped = TERM_POS;
      end else if (prod_ext < TERM_NEG) begin
         term_clamped = TERM_NEG;
      end else begin
         term_clamped = prod_ext;
      end
      mul_last = (step_ff == mspc_pkg::STEP_W'(mspc_pkg::GAIN_W - 1));
   end

   // Truncate the Q.20 sum to a whole duty and clamp
   always_comb begin
      if (total_ff[TW-1] || (total_ff == '0)) begin
         duty_val = '0;
      end else if (|total_ff[TW-2:mspc_pkg::FRAC_OUT + mspc_pkg::DUTY_W]) begin
         duty_val = mspc_pkg::DUTY_MAX;
      end else begin
         duty_val = total_ff[mspc_pkg::FRAC_OUT + mspc_pkg::DUTY_W - 1:mspc_pkg::FRAC_OUT];
      end
   end

   // Sequence one tick through measurement and the three PID terms
   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      last_level_in  = last_level_ff;
      edge_count_in  = edge_count_ff;
      window_in      = window_ff;
      speed_in       = speed_ff;
      error_sum_in   = error_sum_ff;
      last_error_in  = last_error_ff;
      deriv_in       = deriv_ff;
      updated_in     = updated_ff;
      mcand_in       = mcand_ff;
      mplier_in      = mplier_ff;
      prod_in        = prod_ff;
      step_in        = step_ff;
      total_in       = total_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_duty_in    = rsp_duty_ff;
      rsp_speed_in   = rsp_speed_ff;
      rsp_updated_in = rsp_updated_ff;

      case (state_ff)
         mspc_pkg::ST_IDLE: begin
            if (req_take) begin
               last_level_in = req_encoder_a;
               if (window_close) begin
                  edge_count_in = '0;
                  window_in     = '0;
                  updated_in    = 1'b1;
                  mcand_in      = $signed({{(PW-COUNT_WIDTH){1'b0}}, edge_next});
                  mplier_in     = scale_ff;
                  prod_in       = '0;
                  step_in       = '0;
                  state_in      = mspc_pkg::ST_SPEED;
               end else begin
                  edge_count_in = edge_next;
                  window_in     = window_next;
                  updated_in    = 1'b0;
                  state_in      = mspc_pkg::ST_ERROR;
               end
            end
         end
         mspc_pkg::ST_SPEED, mspc_pkg::ST_MUL: begin
            // One multiplier bit per cycle
            prod_in   = prod_ff + (mplier_ff[0] ? mcand_ff : '0);
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff + 1'b1;
            if (mul_last) begin
               state_in = (state_ff == mspc_pkg::ST_SPEED) ? mspc_pkg::ST_SATURATE
                                                           : mspc_pkg::ST_ADD;
            end
         end
         mspc_pkg::ST_SATURATE: begin
            if (|prod_ff[PW-1:mspc_pkg::SPEED_W + mspc_pkg::SPEED_SH]) begin
               speed_in = mspc_pkg::SPEED_MAX;
            end else begin
               speed_in = prod_ff[mspc_pkg::SPEED_W + mspc_pkg::SPEED_SH - 1:mspc_pkg::SPEED_SH];
            end
            state_in = mspc_pkg::ST_ERROR;
         end
         mspc_pkg::ST_ERROR: begin
            if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
               error_sum_in = sum_ext[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
            end else begin
               error_sum_in = sum_ext[SUM_WIDTH-1:0];
            end
            deriv_in      = $signed({err_val[mspc_pkg::ERR_W-1], err_val})
                          - $signed({last_error_ff[mspc_pkg::ERR_W-1], last_error_ff});
            last_error_in = err_val;
            mcand_in      = $signed({{(PW - mspc_pkg::ERR_W){err_val[mspc_pkg::ERR_W-1]}},
                                     err_val});
            mplier_in     = gain_p_ff;
            prod_in       = '0;
            step_in       = '0;
            total_in      = '0;
            phase_in      = mspc_pkg::PH_P;
            state_in      = mspc_pkg::ST_MUL;
         end
         mspc_pkg::ST_ADD: begin
            total_in = total_ff + term_clamped;
            prod_in  = '0;
            step_in  = '0;
            case (phase_ff)
               mspc_pkg::PH_P: begin
                  mcand_in  = $signed({{(PW-SUM_WIDTH){error_sum_ff[SUM_WIDTH-1]}},
                                       error_sum_ff});
                  mplier_in = gain_i_ff;
                  phase_in  = mspc_pkg::PH_I;
                  state_in  = mspc_pkg::ST_MUL;
               end
               mspc_pkg::PH_I: begin
                  mcand_in  = $signed({{(PW - mspc_pkg::DERIV_W){deriv_ff[mspc_pkg::DERIV_W-1]}},
                                       deriv_ff});
                  mplier_in = gain_d_ff;
                  phase_in  = mspc_pkg::PH_D;
                  state_in  = mspc_pkg::ST_MUL;
               end
               default: begin
                  state_in = mspc_pkg::ST_FINISH;
               end
            endcase
         end
         mspc_pkg::ST_FINISH: begin
            // Hold until the output register is free
            if (rsp_load) begin
               rsp_valid_in   = 1'b1;
               rsp_duty_in    = duty_val;
               rsp_speed_in   = speed_ff;
               rsp_updated_in = updated_ff;
               state_in       = mspc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mspc_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mspc_pkg::ST_IDLE;
         phase_ff      <= mspc_pkg::PH_P;
         last_level_ff <= 1'b0;
         edge_count_ff <= '0;
         window_ff     <= '0;
         speed_ff      <= '0;
         error_sum_ff  <= '0;
         last_error_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         last_level_ff <= last_level_in;
         edge_count_ff <= edge_count_in;
         window_ff     <= window_in;
         speed_ff      <= speed_in;
         error_sum_ff  <= error_sum_in;
         last_error_ff <= last_error_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      deriv_ff       <= deriv_in;
      updated_ff     <= updated_in;
      mcand_ff       <= mcand_in;
      mplier_ff      <= mplier_in;
      prod_ff        <= prod_in;
      step_ff        <= step_in;
      total_ff       <= total_in;
      rsp_duty_ff    <= rsp_duty_in;
      rsp_speed_ff   <= rsp_speed_in;
      rsp_updated_ff <= rsp_updated_in;
   end

   // A taken word makes the block busy in the next cycle
   `MSPC_ASSERT_NEXT(a_busy_after_take, req_take, !req_ready)
   // Speed saturation only follows a completed speed product
   `MSPC_ASSERT_NEXT(a_sat_after_speed, (state_ff == mspc_pkg::ST_SPEED) && mul_last,
                     state_ff == mspc_pkg::ST_SATURATE)
   // A loaded result is presented in the next cycle
   `MSPC_ASSERT_NEXT(a_load_shows, rsp_load, rsp_valid && !req_ready == 1'b0)
   // A waiting result is never overwritten by the finish step
   `MSPC_ASSERT_SAME(a_no_overwrite, rsp_load && rsp_valid, rsp_ready)

endmodule

`default_nettype wire
